[rtl/core/pps_offset_statistics_assert.svh]
// ----------------------------------------------------------------------------
// PPS offset statistics assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PPS_OFFSET_STATISTICS_ASSERT_SVH
`define PPS_OFFSET_STATISTICS_ASSERT_SVH

// Same-cycle implication.
`define PPSOFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PPSOFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ppsofs_pkg.sv]
// ----------------------------------------------------------------------------
// PPS offset statistics package
// Widths, constants and types shared by the statistics core and its divider.
// ----------------------------------------------------------------------------
package ppsofs_pkg;

	localparam int COUNT_BITS     = 32;
	localparam int MEAN_FRAC_BITS = 16;
	localparam int NS_W           = 30;
	localparam int OFS_W          = 30;
	localparam int MAG_W          = 29;
	localparam int MARGIN_W       = 29;
	localparam int STAT_W         = 32;
	localparam int MEAN_W         = 47;
	localparam int MEAN_OUT_W     = 46;
	localparam int WIDE_W         = 48;
	localparam int SUM_W          = 63;
	localparam int DIV_STEPS      = WIDE_W;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
	localparam int MUL_DIG_W      = 16;
	localparam int MUL_STEPS      = WIDE_W / MUL_DIG_W;
	localparam int MUL_CNT_W      = $clog2(MUL_STEPS);
	localparam int PROD_W         = WIDE_W + MUL_DIG_W;
	localparam int ACC_W          = 2 * WIDE_W;
	localparam int IN_TDATA_W     = 64;
	localparam int OUT_TDATA_W    = 304;

	localparam logic [NS_W:0]       NS_PER_SEC = 31'd1000000000;
	localparam logic [NS_W-1:0]     HALF_SEC   = 30'd500000000;
	localparam logic [STAT_W-1:0]   STAT_MAX   = {STAT_W{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

	typedef enum logic {
		REG_EDGE_SELECT = 1'b0,
		REG_MARGIN_NS   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_ERROR,
		ST_MULTIPLY,
		ST_WRITE
	} state_t;

endpackage

[rtl/core/ppsofs_div.sv]
// ----------------------------------------------------------------------------
// PPS offset statistics divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppsofs_div import ppsofs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WIDE_W-1:0]     dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic [WIDE_W-1:0]     quotient,
	output logic                  done
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0]     quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [COUNT_BITS:0]   trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[WIDE_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDE_W-2:0], fits};
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, div_q}) : trial[COUNT_BITS-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/core/pps_offset_statistics.sv]
// ----------------------------------------------------------------------------
// PPS offset statistics
// Running offset statistics of pulse-per-second timestamps.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one pulse's assert and clear nanosecond
// timestamps and yields one result transfer with the folded offset, the
// out-of-margin flag, the counters, the peak offset, the running mean and the
// running sum of squared deviations. A pulse goes from its input transfer to
// its result through 48 steps of the restoring divider of the mean update, a
// step to apply the mean, a step to form the error, three multiply steps for
// the squared deviation term and the write step. The input is ready again the
// cycle after the write. The input is not ready while a pulse is at work; a
// result waiting at the output does not stop the next pulse from being taken,
// but it holds that pulse in its write step until the result is taken.
module pps_offset_statistics import ppsofs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [MARGIN_W-1:0]    cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// assert_nsec [29:0], clear_nsec [59:30], zero fill above.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// offset_ns [29:0], out_of_margin [30], sample_total [62:31],
	// overflow_total [94:63], unsync_run [126:95], longest_unsync [158:127],
	// peak_divergence [187:159], mean_q16 [233:188], sum_sq_dev [296:234].
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	state_t                 state_q, state_nx;
	logic                   div_start;
	logic                   div_done;
	logic                   in_fire;
	logic                   load_out;
	logic                   mul_last;

	logic                   edge_select_q;
	logic [MARGIN_W-1:0]    margin_q;

	logic [COUNT_BITS-1:0]  count_q;
	logic [STAT_W-1:0]      overflow_q;
	logic [STAT_W-1:0]      run_q;
	logic [STAT_W-1:0]      longest_q;
	logic [MAG_W-1:0]       peak_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [SUM_W-1:0]       sumsq_q;

	logic [OFS_W-1:0]       off_q;
	logic                   oom_q;
	logic [WIDE_W-1:0]      x_q;
	logic                   d_neg_q;
	logic [WIDE_W-1:0]      dm_q;
	logic [WIDE_W-1:0]      em_q;
	logic [ACC_W-1:0]       acc_q;
	logic [MUL_CNT_W-1:0]   mul_k_q;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [NS_W-1:0]        ns;
	logic signed [NS_W:0]   off_full;
	logic [OFS_W-1:0]       off;
	logic [OFS_W-1:0]       off_abs;
	logic [MAG_W-1:0]       mag;
	logic                   oom;
	logic [WIDE_W-1:0]      x;
	logic [WIDE_W-1:0]      d;
	logic [WIDE_W-1:0]      dm;
	logic [COUNT_BITS-1:0]  count_nx;
	logic [WIDE_W-1:0]      dividend;
	logic [WIDE_W-1:0]      quotient;
	logic [WIDE_W-1:0]      q_signed;
	logic [WIDE_W-1:0]      e;
	logic [PROD_W-1:0]      pp;
	logic [ACC_W-1:0]       pp_shift;
	logic [ACC_W-WIDE_W+15:0] term_raw;
	logic [SUM_W-1:0]       term;
	logic [SUM_W:0]         sum_full;
	logic [SUM_W-1:0]       sum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_select_q <= 1'b0;
			margin_q      <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EDGE_SELECT: edge_select_q <= cfg_wdata[0];
				REG_MARGIN_NS:   margin_q      <= cfg_wdata;
				default:         margin_q      <= margin_q;
			endcase
		end
	end

	always_comb begin
		ns       = edge_select_q ? s_axis_tdata[NS_W-1:0] : s_axis_tdata[2*NS_W-1:NS_W];
		off_full = (ns > HALF_SEC) ? signed'({1'b0, ns}) - signed'(NS_PER_SEC)
		                           : signed'({1'b0, ns});
		off      = off_full[OFS_W-1:0];
		off_abs  = off[OFS_W-1] ? OFS_W'(-off) : off;
		mag      = off_abs[MAG_W-1:0];
		oom      = mag >= margin_q;
		x        = {{(WIDE_W-OFS_W-MEAN_FRAC_BITS){off[OFS_W-1]}}, off, {MEAN_FRAC_BITS{1'b0}}};
		d        = x - {mean_q[MEAN_W-1], mean_q};
		dm       = d[WIDE_W-1] ? WIDE_W'(-d) : d;
		count_nx = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
		dividend = dm + WIDE_W'(count_nx >> 1);
	end

	always_comb begin
		q_signed = d_neg_q ? WIDE_W'(-quotient) : quotient;
		e        = x_q - {mean_q[MEAN_W-1], mean_q};
		pp       = PROD_W'(dm_q * em_q[MUL_DIG_W*mul_k_q +: MUL_DIG_W]);
		pp_shift = ACC_W'(pp) << (MUL_DIG_W * mul_k_q);
		term_raw = acc_q[ACC_W-1:2*MEAN_FRAC_BITS];
		term     = term_raw[SUM_W] ? SUM_MAX : term_raw[SUM_W-1:0];
		sum_full = {1'b0, sumsq_q} + {1'b0, term};
		sum_nx   = sum_full[SUM_W] ? SUM_MAX : sum_full[SUM_W-1:0];
	end

	ppsofs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count_nx),
		.quotient (quotient),
		.done     (div_done)
	);

	assign mul_last = mul_k_q == MUL_CNT_W'(MUL_STEPS - 1);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_axis_tvalid) state_nx = ST_DIVIDE;
			ST_DIVIDE:   if (div_done) state_nx = ST_ERROR;
			ST_ERROR:    state_nx = ST_MULTIPLY;
			ST_MULTIPLY: if (mul_last) state_nx = ST_WRITE;
			ST_WRITE:    if (!out_valid_q || m_axis_tready) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		in_fire       = s_axis_tready && s_axis_tvalid;
		div_start     = in_fire;
		load_out      = (state_q == ST_WRITE) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			overflow_q  <= '0;
			run_q       <= '0;
			longest_q   <= '0;
			peak_q      <= '0;
			mean_q      <= '0;
			sumsq_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				count_q <= count_nx;
				if (mag > peak_q) begin
					peak_q <= mag;
				end
				if (oom) begin
					if (overflow_q != STAT_MAX) overflow_q <= overflow_q + 1'b1;
					if (run_q != STAT_MAX) run_q <= run_q + 1'b1;
				end else begin
					if (run_q > longest_q) longest_q <= run_q;
					run_q <= '0;
				end
			end
			if ((state_q == ST_DIVIDE) && div_done) begin
				mean_q <= mean_q + q_signed[MEAN_W-1:0];
			end
			if (load_out) begin
				sumsq_q <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			off_q   <= off;
			oom_q   <= oom;
			x_q     <= x;
			d_neg_q <= d[WIDE_W-1];
			dm_q    <= dm;
		end
		if (state_q == ST_ERROR) begin
			em_q    <= e[WIDE_W-1] ? WIDE_W'(-e) : e;
			acc_q   <= '0;
			mul_k_q <= '0;
		end else if (state_q == ST_MULTIPLY) begin
			acc_q   <= acc_q + pp_shift;
			mul_k_q <= mul_k_q + 1'b1;
		end
		if (load_out) begin
			out_data_q <= {7'b0, sum_nx, mean_q[MEAN_OUT_W-1:0], peak_q, longest_q, run_q,
			               overflow_q, STAT_W'(count_q), oom_q, off_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`include "pps_offset_statistics_assert.svh"

	`PPSOFS_ASSERT_NXT(a_accept_starts_divide, in_fire, state_q == ST_DIVIDE,
		"Accepted pulse did not start the divider.")
	`PPSOFS_ASSERT_NXT(a_write_loads_output, load_out, m_axis_tvalid,
		"Result was not presented after the write step.")
	`PPSOFS_ASSERT_IMP(a_run_within_overflow, 1'b1, run_q <= overflow_q,
		"Current run exceeds the out-of-margin total.")
	`PPSOFS_ASSERT_IMP(a_longest_within_overflow, 1'b1, longest_q <= overflow_q,
		"Longest run exceeds the out-of-margin total.")

endmodule
